// ----- hw/rtl/ifmt_pkg.sv -----
// Package for the integer field formatter: conversion codes, prefix codes,
// character constants, controller states and the command and status structs.
// Depends on nothing.
`default_nettype none

package ifmt_pkg;

   localparam logic [2:0] ACT_SIGNED_DEC = 3'd0;
   localparam logic [2:0] ACT_UNSIGNED_DEC = 3'd1;
   localparam logic [2:0] ACT_LOWER_HEX = 3'd2;
   localparam logic [2:0] ACT_UPPER_HEX = 3'd3;
   localparam logic [2:0] ACT_POINTER = 3'd4;

   localparam logic [1:0] PFX_NONE = 2'd0;
   localparam logic [1:0] PFX_MINUS = 2'd1;
   localparam logic [1:0] PFX_HEX = 2'd2;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_X = 8'h78;
   localparam logic [7:0] CH_UPPER_BASE = 8'h37;
   localparam logic [7:0] CH_LOWER_BASE = 8'h57;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_MEASURE,
      ST_PLAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic convert;
      logic measure;
      logic plan;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_hex;
      logic conv_done;
      logic emit_done;
   } status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/ifmt_ctrl.sv -----
// Controller state machine of the integer field formatter.
// Depends on ifmt_pkg for the state type and the command and status structs.
`default_nettype none

module ifmt_ctrl
   import ifmt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (status.is_hex || status.conv_done) begin
               state_in = ST_MEASURE;
            end
         end
         ST_MEASURE: begin
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         ST_CONVERT: begin
            cmd.convert = !status.is_hex;
         end
         ST_MEASURE: begin
            cmd.measure = 1'b1;
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = !status.emit_done;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/ifmt_datapath.sv -----
// Datapath of the integer field formatter: operand capture, binary to BCD
// conversion, digit count, field layout and the character output register.
// Depends on ifmt_pkg for codes, characters and the command and status structs.
`default_nettype none

module ifmt_datapath
   import ifmt_pkg::*;
#(
   parameter int MAX_FIELD = 62
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire logic [2:0]  req_action,
   input  wire logic [63:0] req_value,
   input  wire logic [5:0]  req_field_width,
   input  wire logic        req_precision_given,
   input  wire logic [5:0]  req_precision,
   input  wire logic        req_left_align,
   input  wire logic        req_zero_pad,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_last
);

   localparam logic [5:0] MaxField = 6'(MAX_FIELD);

   logic        is_hex_ff, is_hex_in;
   logic        upper_ff, upper_in;
   logic [1:0]  prefix_ff, prefix_in;
   logic [5:0]  width_ff, width_in;
   logic        pgiven_ff, pgiven_in;
   logic [5:0]  prec_ff, prec_in;
   logic        left_ff, left_in;
   logic        zpad_ff, zpad_in;
   logic [31:0] bin_ff, bin_in;
   logic [63:0] dig_ff, dig_in;
   logic [4:0]  iter_ff, iter_in;
   logic [4:0]  ndig_ff, ndig_in;
   logic [6:0]  b1_ff, b1_in;
   logic [6:0]  b2_ff, b2_in;
   logic [6:0]  b3_ff, b3_in;
   logic [6:0]  b4_ff, b4_in;
   logic [6:0]  total_ff, total_in;
   logic [6:0]  pos_ff, pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_char_ff, rsp_char_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [31:0] low_word;
   logic        negative;
   logic [31:0] magnitude;
   logic        act_hex;
   logic [39:0] bcd_adj;
   logic [3:0]  nib;
   logic [4:0]  top_digit;
   logic [6:0]  eff_len;
   logic [6:0]  body_len;
   logic [6:0]  nd_p;
   logic [6:0]  w7;
   logic [6:0]  p7;
   logic        width_pad;
   logic [6:0]  lead_len;
   logic [6:0]  zero_len;
   logic [6:0]  trail_len;
   logic        out_free;
   logic        load_char;
   logic [6:0]  dig_pos;
   logic [3:0]  dig_val;
   logic [7:0]  emit_char;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_hex_ff   <= is_hex_in;
      upper_ff    <= upper_in;
      prefix_ff   <= prefix_in;
      width_ff    <= width_in;
      pgiven_ff   <= pgiven_in;
      prec_ff     <= prec_in;
      left_ff     <= left_in;
      zpad_ff     <= zpad_in;
      bin_ff      <= bin_in;
      dig_ff      <= dig_in;
      iter_ff     <= iter_in;
      ndig_ff     <= ndig_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      b3_ff       <= b3_in;
      b4_ff       <= b4_in;
      total_ff    <= total_in;
      pos_ff      <= pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      low_word = req_value[31:0];
      negative = (req_action == ACT_SIGNED_DEC) && low_word[31];
      magnitude = negative ? (32'd0 - low_word) : low_word;
      act_hex = (req_action == ACT_LOWER_HEX) || (req_action == ACT_UPPER_HEX)
         || (req_action == ACT_POINTER);
   end

   always_comb begin
      for (int i = 0; i < 10; i++) begin
         nib = dig_ff[4 * i +: 4];
         bcd_adj[4 * i +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
      end
   end

   always_comb begin
      top_digit = 5'd0;
      for (int i = 0; i < 16; i++) begin
         if (dig_ff[4 * i +: 4] != 4'd0) begin
            top_digit = 5'(i + 1);
         end
      end
   end

   always_comb begin
      p7 = {5'd0, prefix_ff};
      w7 = {1'b0, width_ff};
      eff_len = (pgiven_ff && ({1'b0, prec_ff} > {2'b00, ndig_ff}))
         ? {1'b0, prec_ff} : {2'b00, ndig_ff};
      body_len = eff_len + p7;
      nd_p = {2'b00, ndig_ff} + p7;
      width_pad = zpad_ff && !left_ff && !pgiven_ff;
      lead_len = (!left_ff && !width_pad && (body_len < w7)) ? (w7 - body_len) : 7'd0;
      trail_len = (left_ff && (body_len < w7)) ? (w7 - body_len) : 7'd0;
      priority if (width_pad && (nd_p < w7)) begin
         zero_len = w7 - nd_p;
      end else if (pgiven_ff && ({2'b00, ndig_ff} < {1'b0, prec_ff})) begin
         zero_len = {1'b0, prec_ff} - {2'b00, ndig_ff};
      end else begin
         zero_len = 7'd0;
      end
   end

   always_comb begin
      dig_pos = b4_ff - 7'd1 - pos_ff;
      dig_val = dig_ff[4 * dig_pos[3:0] +: 4];
      priority if (pos_ff < b1_ff) begin
         emit_char = CH_SPACE;
      end else if (pos_ff < b2_ff) begin
         if (prefix_ff == PFX_MINUS) begin
            emit_char = CH_MINUS;
         end else if (pos_ff == b1_ff) begin
            emit_char = CH_ZERO;
         end else begin
            emit_char = CH_X;
         end
      end else if (pos_ff < b3_ff) begin
         emit_char = CH_ZERO;
      end else if (pos_ff < b4_ff) begin
         if (dig_val < 4'd10) begin
            emit_char = CH_ZERO + {4'd0, dig_val};
         end else if (upper_ff) begin
            emit_char = CH_UPPER_BASE + {4'd0, dig_val};
         end else begin
            emit_char = CH_LOWER_BASE + {4'd0, dig_val};
         end
      end else begin
         emit_char = CH_SPACE;
      end
   end

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      load_char = cmd.emit && out_free;
   end

   always_comb begin
      is_hex_in = is_hex_ff;
      upper_in = upper_ff;
      prefix_in = prefix_ff;
      width_in = width_ff;
      pgiven_in = pgiven_ff;
      prec_in = prec_ff;
      left_in = left_ff;
      zpad_in = zpad_ff;
      bin_in = bin_ff;
      dig_in = dig_ff;
      iter_in = iter_ff;
      ndig_in = ndig_ff;
      b1_in = b1_ff;
      b2_in = b2_ff;
      b3_in = b3_ff;
      b4_in = b4_ff;
      total_in = total_ff;
      pos_in = pos_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         is_hex_in = act_hex;
         upper_in = (req_action == ACT_UPPER_HEX);
         if (req_action == ACT_POINTER) begin
            prefix_in = PFX_HEX;
            dig_in = req_value;
         end else if (negative) begin
            prefix_in = PFX_MINUS;
            dig_in = 64'd0;
         end else begin
            prefix_in = PFX_NONE;
            dig_in = act_hex ? {32'd0, low_word} : 64'd0;
         end
         width_in = (req_field_width > MaxField) ? MaxField : req_field_width;
         prec_in = (req_precision > MaxField) ? MaxField : req_precision;
         pgiven_in = req_precision_given;
         left_in = req_left_align;
         zpad_in = req_zero_pad;
         bin_in = magnitude;
         iter_in = 5'd0;
      end

      if (cmd.convert) begin
         dig_in = {24'd0, bcd_adj[38:0], bin_ff[31]};
         bin_in = {bin_ff[30:0], 1'b0};
         iter_in = iter_ff + 5'd1;
      end

      if (cmd.measure) begin
         if ((top_digit == 5'd0) && pgiven_ff && (prec_ff == 6'd0)) begin
            ndig_in = 5'd0;
         end else if (top_digit == 5'd0) begin
            ndig_in = 5'd1;
         end else begin
            ndig_in = top_digit;
         end
      end

      if (cmd.plan) begin
         b1_in = lead_len;
         b2_in = lead_len + p7;
         b3_in = lead_len + p7 + zero_len;
         b4_in = lead_len + p7 + zero_len + {2'b00, ndig_ff};
         total_in = lead_len + p7 + zero_len + {2'b00, ndig_ff} + trail_len;
         pos_in = 7'd0;
      end

      if (load_char) begin
         rsp_char_in = emit_char;
         rsp_last_in = (pos_ff + 7'd1) == total_ff;
         rsp_valid_in = 1'b1;
         pos_in = pos_ff + 7'd1;
      end
   end

   always_comb begin
      status.is_hex = is_hex_ff;
      status.conv_done = &iter_ff;
      status.emit_done = (pos_ff == total_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_last = rsp_last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/integer_field_formatter.sv -----
// Integer field formatter top level: controller and datapath.
// Depends on ifmt_pkg, ifmt_ctrl and ifmt_datapath.
//
// Usage: a request on the req_ channel carries one integer, a conversion
// code and the width, precision, left-align and zero-pad options. The block
// answers with the formatted ASCII text on the rsp_ channel, one character
// per response, with rsp_last set on the final character. A request whose
// text is empty produces no responses.
// Timing: decimal conversions run a binary to BCD shifter one bit per cycle
// through the low word; hex and pointer conversions skip the shifter. Digit
// count and field layout follow in the measure and plan states, and then the
// first character is registered. Then one character leaves per cycle while
// rsp_stall is low, and after the last the controller returns to idle and
// takes the next request. req_stall is high from acceptance until the
// controller is back in idle.
// When the receiver raises rsp_stall the held character stays and emission
// pauses. Reset clears the controller and the response valid flag.
`default_nettype none

module integer_field_formatter
   import ifmt_pkg::*;
#(
   parameter int MAX_FIELD = 62
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_action,
   input  wire logic [63:0] req_value,
   input  wire logic [5:0]  req_field_width,
   input  wire logic        req_precision_given,
   input  wire logic [5:0]  req_precision,
   input  wire logic        req_left_align,
   input  wire logic        req_zero_pad,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_last
);

   cmd_type    cmd;
   status_type status;

   ifmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ifmt_datapath #(
      .MAX_FIELD (MAX_FIELD)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_action),
      .req_value           (req_value),
      .req_field_width     (req_field_width),
      .req_precision_given (req_precision_given),
      .req_precision       (req_precision),
      .req_left_align      (req_left_align),
      .req_zero_pad        (req_zero_pad),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_char        (rsp_out_char),
      .rsp_last            (rsp_last)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/ifmt_checker.sv -----
// Port-level checker for the integer field formatter, bound to the top level.
// Depends only on the ports of integer_field_formatter.
`default_nettype none

module ifmt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_out_char,
   input wire logic        rsp_last
);

   logic [7:0] c;
   assign c = rsp_out_char;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response valid after reset.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("A second request was accepted while one is in progress.");

   a_stalled_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_char)
         && $stable(rsp_last)))
      else $error("Stalled response changed.");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((c == 8'h20) || (c == 8'h2d) || (c == 8'h78)
         || ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46))
         || ((c >= 8'h61) && (c <= 8'h66))))
      else $error("Response character outside the formatter's set.");

endmodule

bind integer_field_formatter ifmt_checker u_checker (.*);

`default_nettype wire

// ----- verif/integer_field_formatter_tb.sv -----
// Self-checking testbench for integer_field_formatter: it formats each request
// itself and compares every response character and last flag in order.
// Depends on ifmt_pkg and the integer_field_formatter RTL.
`timescale 1ns / 1ps

module integer_field_formatter_tb;
   import ifmt_pkg::*;

   localparam int FIELD_MAX = 62;
   localparam int TEXT_LIMIT = 64;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [2:0]  action;
      logic [63:0] value;
      logic [5:0]  field_width;
      logic        precision_given;
      logic [5:0]  precision;
      logic        left_align;
      logic        zero_pad;
   } fmt_request_type;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } fmt_char_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_action;
   logic [63:0] req_value;
   logic [5:0]  req_field_width;
   logic        req_precision_given;
   logic [5:0]  req_precision;
   logic        req_left_align;
   logic        req_zero_pad;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_char;
   logic        rsp_last;

   fmt_char_type expected_chars[$];
   int        fail_count = 0;
   int        cycle_count = 0;
   int        hold_cycles = 0;
   bit        idle_enabled = 1'b1;

   integer_field_formatter uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_value(req_value),
      .req_field_width(req_field_width),
      .req_precision_given(req_precision_given),
      .req_precision(req_precision),
      .req_left_align(req_left_align),
      .req_zero_pad(req_zero_pad),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_char(rsp_out_char),
      .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic void predict_text(input fmt_request_type r);
      int          width;
      int          prec;
      int          pfx_len;
      int          ndig;
      int          body;
      int          d;
      int          i;
      logic [1:0]  pfx;
      logic [63:0] n;
      logic [63:0] t;
      logic [63:0] base;
      logic [31:0] low;
      logic        upper;
      logic [7:0]  digits [24];
      logic [7:0]  text [$];
      fmt_char_type c;

      width = (r.field_width > FIELD_MAX) ? FIELD_MAX : int'(r.field_width);
      prec = (r.precision > FIELD_MAX) ? FIELD_MAX : int'(r.precision);
      if (!r.precision_given)
         prec = -1;
      upper = (r.action == ACT_UPPER_HEX);
      base = (r.action == ACT_LOWER_HEX || r.action == ACT_UPPER_HEX ||
              r.action == ACT_POINTER) ? 64'd16 : 64'd10;

      low = r.value[31:0];
      pfx = PFX_NONE;
      if (r.action == ACT_POINTER) begin
         n = r.value;
         pfx = PFX_HEX;
      end else if (r.action == ACT_SIGNED_DEC && low[31]) begin
         n = 64'h1_0000_0000 - {32'd0, low};
         pfx = PFX_MINUS;
      end else begin
         n = {32'd0, low};
      end
      pfx_len = (pfx == PFX_HEX) ? 2 : ((pfx == PFX_MINUS) ? 1 : 0);

      ndig = 0;
      if (!(n == 0 && prec == 0)) begin
         t = n;
         do begin
            d = int'(t % base);
            if (d >= 10)
               digits[ndig] = (upper ? CH_UPPER_BASE : CH_LOWER_BASE) + 8'(d);
            else
               digits[ndig] = CH_ZERO + 8'(d);
            ndig++;
            t = t / base;
         end while (t != 0);
      end

      body = (ndig < prec) ? prec + pfx_len : ndig + pfx_len;

      if (!r.left_align && !(r.zero_pad && prec < 0) && body < width)
         repeat (width - body) text.push_back(CH_SPACE);
      if (pfx == PFX_HEX) begin
         text.push_back(CH_ZERO);
         text.push_back(CH_X);
      end else if (pfx == PFX_MINUS) begin
         text.push_back(CH_MINUS);
      end
      if (r.zero_pad && !r.left_align && prec < 0 && ndig + pfx_len < width)
         repeat (width - ndig - pfx_len) text.push_back(CH_ZERO);
      else if (ndig < prec)
         repeat (prec - ndig) text.push_back(CH_ZERO);
      for (i = ndig - 1; i >= 0; i--)
         text.push_back(digits[i]);
      if (r.left_align && body < width)
         repeat (width - body) text.push_back(CH_SPACE);

      for (i = 0; i < text.size() && i < TEXT_LIMIT; i++) begin
         c.ch = text[i];
         c.last = (i == text.size() - 1 || i == TEXT_LIMIT - 1);
         expected_chars.push_back(c);
      end
   endfunction

   function automatic fmt_request_type make_request(input logic [2:0] action,
                                                    input logic [63:0] value,
                                                    input logic [5:0] field_width,
                                                    input logic precision_given,
                                                    input logic [5:0] precision,
                                                    input logic left_align,
                                                    input logic zero_pad);
      fmt_request_type r;
      r.action = action;
      r.value = value;
      r.field_width = field_width;
      r.precision_given = precision_given;
      r.precision = precision;
      r.left_align = left_align;
      r.zero_pad = zero_pad;
      return r;
   endfunction

   function automatic fmt_request_type random_request();
      fmt_request_type r;
      r.action = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
      case ($urandom_range(0, 5))
         0: r.value = {$urandom, 32'd0};
         1: r.value = {$urandom, 32'($urandom_range(0, 20))};
         2: begin
            case ($urandom_range(0, 3))
               0: r.value = {$urandom, 32'h8000_0000};
               1: r.value = {$urandom, 32'hFFFF_FFFF};
               2: r.value = {$urandom, 32'h7FFF_FFFF};
               default: r.value = 64'hFFFF_FFFF_FFFF_FFFF;
            endcase
         end
         3: r.value = {32'd0, $urandom};
         default: r.value = {$urandom, $urandom};
      endcase
      r.field_width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, 16));
      r.precision_given = 1'($urandom_range(0, 1));
      r.precision = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 12));
      r.left_align = 1'($urandom_range(0, 1));
      r.zero_pad = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // Holds the payload until the request is taken, then may leave a gap.
   task automatic send_request(input fmt_request_type r);
      req_valid <= 1'b1;
      req_action <= r.action;
      req_value <= r.value;
      req_field_width <= r.field_width;
      req_precision_given <= r.precision_given;
      req_precision <= r.precision;
      req_left_align <= r.left_align;
      req_zero_pad <= r.zero_pad;
      do
         @(posedge clock);
      while (req_stall);
      predict_text(r);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      send_request(make_request(ACT_SIGNED_DEC, 64'd0, 6'd0, 1'b0, 6'd0, 1'b0, 1'b0));
      send_request(make_request(ACT_SIGNED_DEC, 64'h0000_0000_8000_0000,
                                6'd0, 1'b0, 6'd0, 1'b0, 1'b0));
      send_request(make_request(ACT_SIGNED_DEC, 64'hFFFF_FFFF_7FFF_FFFF,
                                6'd15, 1'b0, 6'd0, 1'b0, 1'b1));
      send_request(make_request(ACT_SIGNED_DEC, 64'h0000_0000_FFFF_FFFF,
                                6'd8, 1'b1, 6'd4, 1'b1, 1'b0));
      send_request(make_request(ACT_UNSIGNED_DEC, 64'h0000_0000_FFFF_FFFF,
                                6'd0, 1'b0, 6'd0, 1'b0, 1'b0));
      send_request(make_request(ACT_UNSIGNED_DEC, 64'd0, 6'd0, 1'b1, 6'd0, 1'b0, 1'b0));
      send_request(make_request(ACT_UNSIGNED_DEC, 64'd0, 6'd5, 1'b1, 6'd0, 1'b0, 1'b1));
      send_request(make_request(ACT_UNSIGNED_DEC, 64'd42, 6'd63, 1'b0, 6'd0, 1'b0, 1'b0));
      send_request(make_request(ACT_UNSIGNED_DEC, 64'd42, 6'd10, 1'b0, 6'd0, 1'b1, 1'b1));
      send_request(make_request(ACT_LOWER_HEX, 64'hFFFF_FFFF_DEAD_BEEF,
                                6'd0, 1'b0, 6'd0, 1'b0, 1'b0));
      send_request(make_request(ACT_UPPER_HEX, 64'h0000_0000_ABCD_EF09,
                                6'd12, 1'b1, 6'd10, 1'b0, 1'b1));
      send_request(make_request(ACT_UPPER_HEX, 64'd255, 6'd6, 1'b0, 6'd0, 1'b0, 1'b1));
      send_request(make_request(ACT_LOWER_HEX, 64'd0, 6'd3, 1'b1, 6'd0, 1'b1, 1'b0));
      send_request(make_request(ACT_POINTER, 64'd0, 6'd0, 1'b0, 6'd0, 1'b0, 1'b0));
      send_request(make_request(ACT_POINTER, 64'd0, 6'd0, 1'b1, 6'd0, 1'b0, 1'b0));
      send_request(make_request(ACT_POINTER, 64'hFFFF_FFFF_FFFF_FFFF,
                                6'd20, 1'b0, 6'd0, 1'b0, 1'b1));
      send_request(make_request(ACT_POINTER, 64'h0123_4567_89AB_CDEF,
                                6'd63, 1'b1, 6'd63, 1'b0, 1'b0));
      send_request(make_request(ACT_POINTER, 64'h1000, 6'd30, 1'b0, 6'd0, 1'b1, 1'b1));
      send_request(make_request(ACT_SIGNED_DEC, 64'h0000_0000_FFFF_FFF6,
                                6'd63, 1'b1, 6'd63, 1'b0, 1'b0));
      send_request(make_request(ACT_SIGNED_DEC, 64'h0000_0000_8000_0000,
                                6'd20, 1'b0, 6'd0, 1'b0, 1'b1));
      send_request(make_request(3'd5, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 1'b0, 6'd0, 1'b0, 1'b0));
      send_request(make_request(3'd6, 64'd123, 6'd7, 1'b1, 6'd5, 1'b0, 1'b0));
      send_request(make_request(3'd7, 64'd0, 6'd4, 1'b1, 6'd0, 1'b1, 1'b1));
      send_request(make_request(ACT_UNSIGNED_DEC, 64'd7, 6'd62, 1'b1, 6'd62, 1'b1, 1'b1));
   endtask

   task automatic test_random_formats(input int count);
      repeat (count) send_request(random_request());
   endtask

   task automatic test_output_backpressure();
      hold_cycles = 300;
      repeat (8) send_request(random_request());
      wait_until_drained();
   endtask

   task automatic test_drain_pause();
      repeat (10) send_request(random_request());
      wait_until_drained();
      repeat (10) send_request(random_request());
   endtask

   task automatic test_no_idling();
      idle_enabled = 1'b0;
      repeat (50) send_request(random_request());
   endtask

   initial begin : rsp_stall_gen
      int burst;
      burst = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            burst = $urandom_range(1, 7) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      fmt_char_type exp_char;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected response: out_char %h last %b", rsp_out_char, rsp_last);
            fail_count++;
         end else begin
            exp_char = expected_chars.pop_front();
            if (rsp_out_char !== exp_char.ch) begin
               $error("out_char mismatch: expected %h actual %h", exp_char.ch, rsp_out_char);
               fail_count++;
            end
            if (rsp_last !== exp_char.last) begin
               $error("last mismatch: expected %b actual %b", exp_char.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_SIGNED_DEC;
      req_value <= 64'd0;
      req_field_width <= 6'd0;
      req_precision_given <= 1'b0;
      req_precision <= 6'd0;
      req_left_align <= 1'b0;
      req_zero_pad <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_formats(190);
      test_output_backpressure();
      test_drain_pause();
      test_no_idling();
      wait_until_drained();

      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/ifmt_pkg.sv
hw/rtl/ifmt_ctrl.sv
hw/rtl/ifmt_datapath.sv
hw/rtl/integer_field_formatter.sv
hw/rtl/ifmt_checker.sv
verif/integer_field_formatter_tb.sv
